FILE: hdl/bve_pkg.sv
package bve_pkg;

  // Default storage and word geometry
  localparam int CAPACITY_BITS = 256;
  localparam int WORD_BITS     = 64;

  // Field widths of the stream words
  localparam int LEN_W        = 9;
  localparam int MODE_W       = 4;
  localparam int POS_W        = 8;
  localparam int CNT_W        = 9;
  localparam int FSEL_W       = 2;
  localparam int FIELD_W      = 64;
  localparam int OUT_CNT_W    = 9;
  localparam int OK_W         = 1;

  // Packed word widths, padded to whole bytes
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 96;

  // Smallest field size; the size code shifts it left
  localparam int FIELD_MIN_BITS = 8;

  // Length after reset
  localparam logic [LEN_W-1:0] RESET_LEN = 9'd256;

  // Operation codes carried in in_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_SET_BIT   = 4'd0,
    MODE_CLR_BIT   = 4'd1,
    MODE_SET_RUN   = 4'd2,
    MODE_CLR_RUN   = 4'd3,
    MODE_OR_FIELD  = 4'd4,
    MODE_RD_FIELD  = 4'd5,
    MODE_SHL       = 4'd6,
    MODE_SHR       = 4'd7,
    MODE_SET_ALL   = 4'd8,
    MODE_CLR_ALL   = 4'd9,
    MODE_QUERY     = 4'd10
  } mode_t;

endpackage

FILE: hdl/bit_vector_engine_top.sv
// Bit vector engine: holds a bit vector of CAPACITY_BITS storage bits, of which the low
// L = min(length, CAPACITY_BITS) are in use, and applies one operation per input word
// (bit or run set/clear, field OR/read, shifts, set/clear all, query). Every result word
// carries an ok flag, the field read, and the popcount and leading/trailing zero counts
// taken within L after the operation; an empty vector reports L for both zero counts.
// The block takes one word every cycle while the result side does not stall. The accepting
// edge updates the vector register and the stage 1 flags, the stage 2 register then takes
// per-word counts of the vector, and the result register then takes the word counts
// combined into the result word. A stall on the result side holds the input side once the
// two internal stages are full. A write on the cfg port sets the length and clears the
// stored bits at or above it in the same cycle; the user must make it only while no word
// is in flight, and the block itself does not enforce this.
module bit_vector_engine_top #(
  parameter int CAPACITY_BITS = bve_pkg::CAPACITY_BITS,
  parameter int WORD_BITS     = bve_pkg::WORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // bit_pos[7:0], count[16:8], field_width[18:17], field_value[82:19], zero pad
  input  logic [bve_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[3:0]
  input  logic [bve_pkg::MODE_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_value[63:0], ones_count[72:64], leading_zeros[81:73],
  // trailing_zeros[90:82], zero pad
  output logic [bve_pkg::OUT_DATA_W-1:0] out_tdata,
  // ok[0]
  output logic [bve_pkg::OK_W-1:0]       out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [bve_pkg::LEN_W-1:0]      cfg_wr_data
);

  localparam int NUM_WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int PAD_BITS  = NUM_WORDS * WORD_BITS;
  localparam int CW        = $clog2(CAPACITY_BITS + 1);
  localparam int EW        = (CW > 10) ? CW : 10;
  localparam int WIDX      = $clog2(WORD_BITS);
  localparam int WC_W      = $clog2(WORD_BITS + 1);
  localparam int FW        = bve_pkg::FIELD_W;
  localparam int OCW       = bve_pkg::OUT_CNT_W;
  localparam int PAD_OUT   = bve_pkg::OUT_DATA_W - FW - 3 * OCW;

  // Per-word statistics
  typedef struct packed {
    logic [WC_W-1:0] cnt;
    logic            nz;
    logic [WIDX-1:0] lo;
    logic [WIDX-1:0] hi;
  } wstat_t;

  function automatic wstat_t word_stat(input logic [WORD_BITS-1:0] x);
    wstat_t          s;
    logic [WORD_BITS-1:0] t;
    logic [WORD_BITS-1:0] h;
    logic [WORD_BITS-1:0] c;
    logic [WIDX-1:0] lzc;
    // popcount as an adder tree: pair sums, nibble sums, byte sums folded together
    c = (x & {(WORD_BITS/2){2'b01}}) + ((x >> 1) & {(WORD_BITS/2){2'b01}});
    c = (c & {(WORD_BITS/4){4'b0011}}) + ((c >> 2) & {(WORD_BITS/4){4'b0011}});
    c = (c + (c >> 4)) & {(WORD_BITS/8){8'h0F}};
    for (int k = 8; k < WORD_BITS; k = k * 2) begin
      c = c + (c >> k);
    end
    s.cnt = c[WC_W-1:0];
    s.nz = |x;
    // binary search for the lowest and highest set bit
    t = x;
    h = x;
    s.lo = '0;
    lzc = '0;
    for (int k = WIDX - 1; k >= 0; k--) begin
      if ((t & ~({WORD_BITS{1'b1}} << (1 << k))) == '0) begin
        s.lo[k] = 1'b1;
        t = t >> (1 << k);
      end
      if ((h & ~({WORD_BITS{1'b1}} >> (1 << k))) == '0) begin
        lzc[k] = 1'b1;
        h = h << (1 << k);
      end
    end
    s.hi = WIDX'(WORD_BITS - 1) - lzc;
    return s;
  endfunction

  // Architectural state
  logic [bve_pkg::LEN_W-1:0] length_r;
  logic [CAPACITY_BITS-1:0]  vec_r;
  logic [CAPACITY_BITS-1:0]  vec_nxt;

  // Stage 1: operation result flags
  logic          s1_v_r;
  logic          s1_ok_r;
  logic [FW-1:0] s1_rd_r;
  logic          ok_nxt;
  logic [FW-1:0] rd_nxt;

  // Stage 2: word statistics
  logic          s2_v_r;
  logic          s2_ok_r;
  logic [FW-1:0] s2_rd_r;
  wstat_t        ws_r   [NUM_WORDS];
  wstat_t        ws_nxt [NUM_WORDS];

  // Result register
  logic           out_v_r;
  logic           out_ok_r;
  logic [FW-1:0]  out_rd_r;
  logic [OCW-1:0] out_ones_r;
  logic [OCW-1:0] out_lz_r;
  logic [OCW-1:0] out_tz_r;
  logic [OCW-1:0] ones_nxt;
  logic [OCW-1:0] lz_nxt;
  logic [OCW-1:0] tz_nxt;

  // Input field unpack
  logic [bve_pkg::MODE_W-1:0] in_mode;
  logic [bve_pkg::POS_W-1:0]  in_pos;
  logic [bve_pkg::CNT_W-1:0]  in_cnt;
  logic [bve_pkg::FSEL_W-1:0] in_fsel;
  logic [FW-1:0]              in_fval;

  assign in_mode = in_tuser;
  assign in_pos  = in_tdata[7:0];
  assign in_cnt  = in_tdata[16:8];
  assign in_fsel = in_tdata[18:17];
  assign in_fval = in_tdata[82:19];

  // Pipeline flow control
  logic out_adv;
  logic s2_adv;
  logic s1_adv;
  logic in_fire;

  assign out_adv   = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r || out_adv;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_tready = s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Effective lengths (current and the one being written)
  logic [EW-1:0] cap_e;
  logic [EW-1:0] len_e;
  logic [EW-1:0] l_e;
  logic [EW-1:0] cfg_len_e;
  logic [EW-1:0] cfg_l_e;

  assign cap_e     = EW'(CAPACITY_BITS);
  assign len_e     = EW'(length_r);
  assign l_e       = (len_e > cap_e) ? cap_e : len_e;
  assign cfg_len_e = EW'(cfg_wr_data);
  assign cfg_l_e   = (cfg_len_e > cap_e) ? cap_e : cfg_len_e;

  // Operand widening
  logic [EW-1:0] pos_e;
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] run_end;
  logic [EW-1:0] fsize_e;
  logic [FW-1:0] fmask;

  assign pos_e   = EW'(in_pos);
  assign cnt_e   = EW'(in_cnt);
  assign run_end = pos_e + cnt_e;
  assign fsize_e = EW'(bve_pkg::FIELD_MIN_BITS) << in_fsel;

  always_comb begin
    unique case (in_fsel)
      2'd0:    fmask = FW'(8'hFF);
      2'd1:    fmask = FW'(16'hFFFF);
      2'd2:    fmask = FW'(32'hFFFF_FFFF);
      default: fmask = '1;
    endcase
  end

  // Per-bit masks
  logic [CAPACITY_BITS-1:0] len_mask;
  logic [CAPACITY_BITS-1:0] cfg_mask;
  logic [CAPACITY_BITS-1:0] run_mask;
  logic [CAPACITY_BITS-1:0] bit_mask;
  logic [CAPACITY_BITS-1:0] field_bits;

  always_comb begin
    for (int i = 0; i < CAPACITY_BITS; i++) begin
      len_mask[i] = EW'(i) < l_e;
      cfg_mask[i] = EW'(i) < cfg_l_e;
      run_mask[i] = (EW'(i) >= pos_e) && (EW'(i) < run_end);
    end
  end

  assign bit_mask   = CAPACITY_BITS'(1) << in_pos;
  assign field_bits = CAPACITY_BITS'(in_fval & fmask) << in_pos;

  // Operation on the vector
  always_comb begin
    vec_nxt = vec_r;
    ok_nxt  = 1'b1;
    rd_nxt  = '0;
    unique case (in_mode)
      bve_pkg::MODE_SET_BIT, bve_pkg::MODE_CLR_BIT: begin
        if (pos_e >= l_e) begin
          ok_nxt = 1'b0;
        end else if (in_mode == bve_pkg::MODE_SET_BIT) begin
          vec_nxt = vec_r | bit_mask;
        end else begin
          vec_nxt = vec_r & ~bit_mask;
        end
      end
      bve_pkg::MODE_SET_RUN, bve_pkg::MODE_CLR_RUN: begin
        if (run_end > l_e) begin
          ok_nxt = 1'b0;
        end else if (in_mode == bve_pkg::MODE_SET_RUN) begin
          vec_nxt = vec_r | run_mask;
        end else begin
          vec_nxt = vec_r & ~run_mask;
        end
      end
      bve_pkg::MODE_OR_FIELD: begin
        if (pos_e + fsize_e > l_e) begin
          ok_nxt = 1'b0;
        end else begin
          vec_nxt = vec_r | field_bits;
        end
      end
      bve_pkg::MODE_RD_FIELD: begin
        // bits at or above L are stored as zero, so they read as zero
        if (pos_e >= l_e) begin
          ok_nxt = 1'b0;
        end else begin
          rd_nxt = FW'(vec_r >> in_pos) & fmask;
        end
      end
      bve_pkg::MODE_SHL: begin
        if (cnt_e >= l_e) begin
          vec_nxt = '0;
        end else begin
          vec_nxt = (vec_r << in_cnt) & len_mask;
        end
      end
      bve_pkg::MODE_SHR: begin
        if (cnt_e >= l_e) begin
          vec_nxt = '0;
        end else begin
          vec_nxt = vec_r >> in_cnt;
        end
      end
      bve_pkg::MODE_SET_ALL: begin
        vec_nxt = len_mask;
      end
      bve_pkg::MODE_CLR_ALL: begin
        vec_nxt = '0;
      end
      bve_pkg::MODE_QUERY: begin
        vec_nxt = vec_r;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Length and vector registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= bve_pkg::RESET_LEN;
      vec_r    <= '0;
    end else if (cfg_wr_en) begin
      length_r <= cfg_wr_data;
      vec_r    <= vec_r & cfg_mask;
    end else if (in_fire) begin
      vec_r    <= vec_nxt;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok_r <= ok_nxt;
      s1_rd_r <= rd_nxt;
    end
  end

  // Word statistics of the updated vector
  logic [PAD_BITS-1:0] vec_pad;

  assign vec_pad = PAD_BITS'(vec_r);

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      ws_nxt[w] = word_stat(vec_pad[w*WORD_BITS +: WORD_BITS]);
    end
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_adv) begin
      s2_ok_r <= s1_ok_r;
      s2_rd_r <= s1_rd_r;
      for (int w = 0; w < NUM_WORDS; w++) begin
        ws_r[w] <= ws_nxt[w];
      end
    end
  end

  // Combine word statistics into the counts
  logic [EW-1:0] ones_e;
  logic [EW-1:0] lo_e;
  logic [EW-1:0] hi1_e;
  logic          any_set;

  always_comb begin
    ones_e  = '0;
    lo_e    = '0;
    hi1_e   = '0;
    any_set = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      ones_e  = ones_e + EW'(ws_r[w].cnt);
      any_set = any_set | ws_r[w].nz;
    end
    // lowest nonzero word wins
    for (int w = NUM_WORDS - 1; w >= 0; w--) begin
      if (ws_r[w].nz) begin
        lo_e = EW'(w * WORD_BITS) + EW'(ws_r[w].lo);
      end
    end
    // highest nonzero word wins
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (ws_r[w].nz) begin
        hi1_e = EW'(w * WORD_BITS) + EW'(ws_r[w].hi) + EW'(1);
      end
    end
    ones_nxt = OCW'(ones_e);
    lz_nxt   = any_set ? OCW'(l_e - hi1_e) : OCW'(l_e);
    tz_nxt   = any_set ? OCW'(lo_e) : OCW'(l_e);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && out_adv) begin
      out_ok_r   <= s2_ok_r;
      out_rd_r   <= s2_rd_r;
      out_ones_r <= ones_nxt;
      out_lz_r   <= lz_nxt;
      out_tz_r   <= tz_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {{PAD_OUT{1'b0}}, out_tz_r, out_lz_r, out_ones_r, out_rd_r};

endmodule

FILE: hdl/bve_checker.sv
module bve_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bve_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bve_pkg::OK_W-1:0]       out_tuser
);

  // A result word waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With the result register empty the block always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held while the result register is empty");

  // Only a successful read returns field bits
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[63:0] != '0) |-> out_tuser[0])
    else $error("field bits returned by a failed operation");

  // An empty vector reports the same length for both zero counts
  a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[72:64] == '0) |-> (out_tdata[81:73] == out_tdata[90:82]))
    else $error("zero counts disagree on an empty vector");

endmodule

bind bit_vector_engine_top bve_props u_bve_props (.*);

FILE: verif/bve_checker.sv
`timescale 1ns / 100ps

// Watches the word, result and cfg channels of the bit vector engine, keeps its own
// copy of the vector and length, predicts each result and compares it field by field.
module bve_checker
  import bve_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OK_W-1:0]       out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [LEN_W-1:0]      cfg_wr_data,
  output int                    status_due,
  output int                    mismatch_count
);

  // One result word as the block reports it
  typedef struct packed {
    logic                 ok;
    logic [FIELD_W-1:0]   read_value;
    logic [OUT_CNT_W-1:0] ones;
    logic [OUT_CNT_W-1:0] lead;
    logic [OUT_CNT_W-1:0] trail;
  } vec_status_t;

  logic [CAPACITY_BITS-1:0] bits_model;
  logic [LEN_W-1:0]         len_model;
  vec_status_t              status_q[$];
  int                       errs;

  function automatic int eff_len();
    return (len_model > CAPACITY_BITS) ? CAPACITY_BITS : int'(len_model);
  endfunction

  // Applies one operation to the model vector and returns the status it yields
  function automatic vec_status_t apply_vector_op(logic [MODE_W-1:0] mode,
                                                  logic [POS_W-1:0] pos,
                                                  logic [CNT_W-1:0] cnt,
                                                  logic [FSEL_W-1:0] fsel,
                                                  logic [FIELD_W-1:0] fval);
    vec_status_t r;
    int lim, span, p, c, ones, lo, hi;
    bit found;
    lim = eff_len();
    span = FIELD_MIN_BITS << fsel;
    p = pos;
    c = cnt;
    r = '0;
    r.ok = 1'b1;
    case (mode)
      MODE_SET_BIT, MODE_CLR_BIT: begin
        if (p >= lim) begin
          r.ok = 1'b0;
        end else begin
          bits_model[p] = (mode == MODE_SET_BIT);
        end
      end
      MODE_SET_RUN, MODE_CLR_RUN: begin
        if (p + c > lim) begin
          r.ok = 1'b0;
        end else begin
          for (int i = 0; i < c; i++) bits_model[p + i] = (mode == MODE_SET_RUN);
        end
      end
      MODE_OR_FIELD: begin
        if (p + span > lim) begin
          r.ok = 1'b0;
        end else begin
          for (int i = 0; i < span; i++) if (fval[i]) bits_model[p + i] = 1'b1;
        end
      end
      MODE_RD_FIELD: begin
        // bits past the length read as zero
        if (p >= lim) begin
          r.ok = 1'b0;
        end else begin
          for (int i = 0; i < span; i++)
            if (p + i < lim) r.read_value[i] = bits_model[p + i];
        end
      end
      MODE_SHL: begin
        if (c >= lim) begin
          bits_model = '0;
        end else begin
          for (int i = lim - 1; i >= 0; i--)
            bits_model[i] = (i >= c) ? bits_model[i - c] : 1'b0;
        end
      end
      MODE_SHR: begin
        if (c >= lim) begin
          bits_model = '0;
        end else begin
          for (int i = 0; i < lim; i++)
            bits_model[i] = (i + c < lim) ? bits_model[i + c] : 1'b0;
        end
      end
      MODE_SET_ALL: begin
        for (int i = 0; i < lim; i++) bits_model[i] = 1'b1;
      end
      MODE_CLR_ALL: begin
        bits_model = '0;
      end
      MODE_QUERY: begin
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase

    // popcount and zero counts within the length
    ones = 0;
    lo = 0;
    hi = 0;
    found = 1'b0;
    for (int i = 0; i < lim; i++) begin
      if (bits_model[i]) begin
        ones++;
        if (!found) lo = i;
        hi = i;
        found = 1'b1;
      end
    end
    r.ones = OUT_CNT_W'(ones);
    r.lead = OUT_CNT_W'(found ? lim - 1 - hi : lim);
    r.trail = OUT_CNT_W'(found ? lo : lim);
    return r;
  endfunction

  task automatic check_field(string what, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      errs++;
    end
  endtask

  // Result side first: a word leaving now belongs to an older input word
  always @(posedge clk) begin
    vec_status_t got, want;
    if (!rst_n) begin
      bits_model = '0;
      len_model = RESET_LEN;
      status_q.delete();
    end else begin
      if (cfg_wr_en) begin
        len_model = cfg_wr_data;
        for (int i = eff_len(); i < CAPACITY_BITS; i++) bits_model[i] = 1'b0;
      end
      if (out_tvalid && out_tready) begin
        got.ok = out_tuser[0];
        got.read_value = out_tdata[0 +: FIELD_W];
        got.ones = out_tdata[FIELD_W +: OUT_CNT_W];
        got.lead = out_tdata[FIELD_W + OUT_CNT_W +: OUT_CNT_W];
        got.trail = out_tdata[FIELD_W + 2 * OUT_CNT_W +: OUT_CNT_W];
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got 0x%0h", $time, got);
          errs++;
        end else begin
          want = status_q.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("read_value", want.read_value, got.read_value);
          check_field("ones_count", want.ones, got.ones);
          check_field("leading_zeros", want.lead, got.lead);
          check_field("trailing_zeros", want.trail, got.trail);
        end
      end
      if (in_tvalid && in_tready) begin
        status_q.push_back(apply_vector_op(in_tuser,
                                           in_tdata[0 +: POS_W],
                                           in_tdata[POS_W +: CNT_W],
                                           in_tdata[POS_W + CNT_W +: FSEL_W],
                                           in_tdata[POS_W + CNT_W + FSEL_W +: FIELD_W]));
      end
    end
    status_due <= status_q.size();
    mismatch_count <= errs;
  end

endmodule

FILE: verif/tb_bit_vector_engine_top.sv
`timescale 1ns / 100ps

module tb_bit_vector_engine_top;
  import bve_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORDS_PER_PHASE = 65;
  localparam int NUM_PHASES = 10;
  // lengths visited, extremes and out-of-range values among them
  localparam logic [LEN_W-1:0] LEN_STEPS [NUM_PHASES] =
    '{9'd1, 9'd0, 9'd256, 9'd64, 9'd200, 9'd511, 9'd8, 9'd130, 9'd300, 9'd255};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OK_W-1:0]       out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]      cfg_wr_data = '0;

  int status_due;
  int mismatch_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int cur_len = CAPACITY_BITS;

  always #2 clk = ~clk;

  bit_vector_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  bve_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .status_due    (status_due),
    .mismatch_count(mismatch_count)
  );

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bit_vector_engine_top: FAIL");
      $finish;
    end
  end

  // Presents one word, with random gaps before it, and returns at its accepting edge
  task automatic send_word(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                           logic [CNT_W-1:0] cnt, logic [FSEL_W-1:0] fsel,
                           logic [FIELD_W-1:0] fval);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[0 +: POS_W] = pos;
    word[POS_W +: CNT_W] = cnt;
    word[POS_W + CNT_W +: FSEL_W] = fsel;
    word[POS_W + CNT_W + FSEL_W +: FIELD_W] = fval;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Holds the sender until every expected result has been seen
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_len(logic [LEN_W-1:0] len);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = (len > CAPACITY_BITS) ? CAPACITY_BITS : int'(len);
  endtask

  // Mostly in-range operations on the current length, some out of range or unknown
  task automatic random_word();
    logic [MODE_W-1:0] mode;
    logic [FSEL_W-1:0] fsel;
    int pos, cnt, span, room;
    fsel = FSEL_W'($urandom_range(3));
    span = FIELD_MIN_BITS << fsel;
    if ($urandom_range(99) < 6) begin
      mode = MODE_W'($urandom_range(15, int'(MODE_QUERY) + 1));
    end else begin
      mode = MODE_W'($urandom_range(int'(MODE_QUERY)));
    end
    if ($urandom_range(9) < 8 && cur_len > 0) begin
      pos = $urandom_range(cur_len - 1);
    end else begin
      pos = $urandom_range(255);
    end
    if (mode == MODE_OR_FIELD && cur_len >= span && $urandom_range(9) < 8) begin
      pos = $urandom_range(cur_len - span);
    end
    room = (cur_len > pos) ? cur_len - pos : 0;
    if ($urandom_range(9) < 8) begin
      cnt = (mode == MODE_SHL || mode == MODE_SHR) ? $urandom_range(8) : $urandom_range(room);
    end else begin
      cnt = $urandom_range(511);
    end
    send_word(mode, POS_W'(pos), CNT_W'(cnt), fsel, {$urandom, $urandom});
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset length
    send_word(MODE_SET_BIT, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_SET_BIT, 8'd255, 9'd0, 2'd0, '0);
    send_word(MODE_QUERY, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_CLR_BIT, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_SET_RUN, 8'd10, 9'd0, 2'd0, '0);
    send_word(MODE_SET_RUN, 8'd200, 9'd56, 2'd0, '0);
    send_word(MODE_SET_RUN, 8'd200, 9'd57, 2'd0, '0);
    send_word(MODE_CLR_RUN, 8'd0, 9'd256, 2'd0, '0);
    send_word(MODE_CLR_RUN, 8'd255, 9'd511, 2'd0, '0);
    send_word(MODE_OR_FIELD, 8'd192, 9'd0, 2'd3, {FIELD_W{1'b1}});
    send_word(MODE_OR_FIELD, 8'd193, 9'd0, 2'd3, {FIELD_W{1'b1}});
    send_word(MODE_OR_FIELD, 8'd0, 9'd0, 2'd0, 64'hFFFF_FFFF_FFFF_FFA5);
    send_word(MODE_OR_FIELD, 8'd100, 9'd0, 2'd1, 64'hFFFF_FFFF_FFFF_1234);
    send_word(MODE_RD_FIELD, 8'd192, 9'd0, 2'd3, '0);
    send_word(MODE_RD_FIELD, 8'd250, 9'd0, 2'd3, '0);
    send_word(MODE_RD_FIELD, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_SHL, 8'd0, 9'd1, 2'd0, '0);
    send_word(MODE_SHR, 8'd0, 9'd3, 2'd0, '0);
    send_word(MODE_SHL, 8'd0, 9'd256, 2'd0, '0);
    send_word(MODE_SET_ALL, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_SHR, 8'd0, 9'd255, 2'd0, '0);
    send_word(MODE_SHL, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_CLR_ALL, 8'd0, 9'd0, 2'd0, '0);
    send_word(4'd15, 8'd0, 9'd0, 2'd0, '0);
    send_word(MODE_SET_ALL, 8'd0, 9'd0, 2'd0, '0);
    drain();

    // random phases, each at its own length, cycling through four idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      write_len(LEN_STEPS[p]);
      repeat (WORDS_PER_PHASE) random_word();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("tb_bit_vector_engine_top: PASS");
    end else begin
      $display("tb_bit_vector_engine_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bve_pkg.sv
hdl/bit_vector_engine_top.sv
hdl/bve_checker.sv
verif/bve_checker.sv
verif/tb_bit_vector_engine_top.sv
